FILE: rtl/core/gls_pkg.sv
package gls_pkg;

  // default coordinate width of the start and end fields
  localparam int unsigned CoordBitsDef = 8;

  // fixed widths of the map size registers and the emitted points
  localparam int unsigned MapDimBits = 9;
  localparam int unsigned PointBits = 10;
  localparam int unsigned CfgIndexBits = 1;

  localparam logic [MapDimBits-1:0] MapWidthRst = 9'd64;
  localparam logic [MapDimBits-1:0] MapHeightRst = 9'd64;

  typedef enum logic {
    ActStart = 1'b0,
    ActStep  = 1'b1
  } action_e;

  typedef enum logic [CfgIndexBits-1:0] {
    CfgMapWidth  = 1'b0,
    CfgMapHeight = 1'b1
  } cfg_idx_e;

  // step direction along one axis, two's complement
  typedef enum logic [1:0] {
    DirZero = 2'b00,
    DirPos  = 2'b01,
    DirNeg  = 2'b11
  } dir_e;

  typedef struct packed {
    logic at_target;
    logic solid;
    logic opaque;
    logic actor;
  } stop_rules_t;

  // control part of one input item
  typedef struct packed {
    action_e     action;
    stop_rules_t rules;
    logic        solid;
    logic        opaque;
    logic        actor;
  } item_ctrl_t;

  // flags of one result item
  typedef struct packed {
    logic point_valid;
    logic last;
  } res_flags_t;

endpackage

FILE: rtl/core/grid_line_stepper.sv
// Bresenham line stepper on a map grid with early stop. A start item (action 0) emits the
// start point, marked last when start equals end. Each step item (action 1) carries the map
// flags of the point emitted last and yields either the next point on the line or a terminal
// marker (point_valid 0, last 1) that repeats the last point; a step with no line running
// yields nothing. It takes one item per clock unless the output stalls. Items pass the input
// register, then one add and compare pass on the registered error term, into the result
// register. The user must write map_width and map_height only while idle; not enforced.
module grid_line_stepper #(
  parameter int unsigned CoordBits = gls_pkg::CoordBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [gls_pkg::CfgIndexBits-1:0]      cfg_index_i,
  input  logic [gls_pkg::MapDimBits-1:0]        cfg_wdata_i,
  // input items
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  action_i,
  input  logic [CoordBits-1:0]                  start_x_i,
  input  logic [CoordBits-1:0]                  start_y_i,
  input  logic [CoordBits-1:0]                  end_x_i,
  input  logic [CoordBits-1:0]                  end_y_i,
  input  logic                                  stop_at_target_i,
  input  logic                                  stop_on_solid_i,
  input  logic                                  stop_on_opaque_i,
  input  logic                                  stop_on_actor_i,
  input  logic                                  cell_solid_i,
  input  logic                                  cell_opaque_i,
  input  logic                                  cell_actor_i,
  // result items
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [gls_pkg::PointBits-1:0]  point_x_o,
  output logic signed [gls_pkg::PointBits-1:0]  point_y_o,
  output logic                                  point_valid_o,
  output logic                                  last_o
);

  logic [gls_pkg::MapDimBits-1:0] map_width_q, map_height_q;

  gls_pkg::item_ctrl_t  in_ctrl, s1_ctrl;
  logic                 s1_valid, adv;
  logic [CoordBits-1:0] s1_start_x, s1_start_y, s1_end_x, s1_end_y;
  logic                 out_free, res_we;
  logic [gls_pkg::PointBits-1:0] res_x, res_y;
  gls_pkg::res_flags_t  res_flags;

  // map size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= gls_pkg::MapWidthRst;
      map_height_q <= gls_pkg::MapHeightRst;
    end else if (cfg_we_i) begin
      unique case (gls_pkg::cfg_idx_e'(cfg_index_i))
        gls_pkg::CfgMapWidth:  map_width_q  <= cfg_wdata_i;
        gls_pkg::CfgMapHeight: map_height_q <= cfg_wdata_i;
      endcase
    end
  end

  // pack the control fields of an item
  assign in_ctrl = '{
    action: gls_pkg::action_e'(action_i),
    rules: '{at_target: stop_at_target_i, solid: stop_on_solid_i,
             opaque: stop_on_opaque_i, actor: stop_on_actor_i},
    solid: cell_solid_i,
    opaque: cell_opaque_i,
    actor: cell_actor_i
  };

  gls_in_stage #(
    .CoordBits(CoordBits)
  ) u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .ctrl_i     (in_ctrl),
    .adv_i      (adv),
    .valid_o    (s1_valid),
    .start_x_o  (s1_start_x),
    .start_y_o  (s1_start_y),
    .end_x_o    (s1_end_x),
    .end_y_o    (s1_end_y),
    .ctrl_o     (s1_ctrl)
  );

  gls_step_unit #(
    .CoordBits(CoordBits)
  ) u_step_unit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s1_valid),
    .start_x_i    (s1_start_x),
    .start_y_i    (s1_start_y),
    .end_x_i      (s1_end_x),
    .end_y_i      (s1_end_y),
    .ctrl_i       (s1_ctrl),
    .map_width_i  (map_width_q),
    .map_height_i (map_height_q),
    .out_free_i   (out_free),
    .adv_o        (adv),
    .res_we_o     (res_we),
    .res_x_o      (res_x),
    .res_y_o      (res_y),
    .res_flags_o  (res_flags)
  );

  gls_out_stage u_out_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_we_i      (res_we),
    .res_x_i       (res_x),
    .res_y_i       (res_y),
    .res_flags_i   (res_flags),
    .out_free_o    (out_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .point_valid_o (point_valid_o),
    .last_o        (last_o)
  );

endmodule

FILE: rtl/core/gls_in_stage.sv
module gls_in_stage #(
  parameter int unsigned CoordBits = gls_pkg::CoordBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CoordBits-1:0]  start_x_i,
  input  logic [CoordBits-1:0]  start_y_i,
  input  logic [CoordBits-1:0]  end_x_i,
  input  logic [CoordBits-1:0]  end_y_i,
  input  gls_pkg::item_ctrl_t   ctrl_i,
  input  logic                  adv_i,
  output logic                  valid_o,
  output logic [CoordBits-1:0]  start_x_o,
  output logic [CoordBits-1:0]  start_y_o,
  output logic [CoordBits-1:0]  end_x_o,
  output logic [CoordBits-1:0]  end_y_o,
  output gls_pkg::item_ctrl_t   ctrl_o
);

  logic                 valid_q, valid_d;
  logic                 load;
  logic [CoordBits-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
  gls_pkg::item_ctrl_t  ctrl_q;

  // hold the item while the step unit cannot take it
  assign in_stall_o = valid_q && !adv_i;
  assign load = in_valid_i && !in_stall_o;
  assign valid_d = in_stall_o ? 1'b1 : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload capture on a transfer
  always_ff @(posedge clk_i) begin
    if (load) begin
      start_x_q <= start_x_i;
      start_y_q <= start_y_i;
      end_x_q   <= end_x_i;
      end_y_q   <= end_y_i;
      ctrl_q    <= ctrl_i;
    end
  end

  assign valid_o   = valid_q;
  assign start_x_o = start_x_q;
  assign start_y_o = start_y_q;
  assign end_x_o   = end_x_q;
  assign end_y_o   = end_y_q;
  assign ctrl_o    = ctrl_q;

endmodule

FILE: rtl/core/gls_step_unit.sv
module gls_step_unit #(
  parameter int unsigned CoordBits = gls_pkg::CoordBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic [CoordBits-1:0]                start_x_i,
  input  logic [CoordBits-1:0]                start_y_i,
  input  logic [CoordBits-1:0]                end_x_i,
  input  logic [CoordBits-1:0]                end_y_i,
  input  gls_pkg::item_ctrl_t                 ctrl_i,
  input  logic [gls_pkg::MapDimBits-1:0]      map_width_i,
  input  logic [gls_pkg::MapDimBits-1:0]      map_height_i,
  input  logic                                out_free_i,
  output logic                                adv_o,
  output logic                                res_we_o,
  output logic [gls_pkg::PointBits-1:0]       res_x_o,
  output logic [gls_pkg::PointBits-1:0]       res_y_o,
  output gls_pkg::res_flags_t                 res_flags_o
);

  localparam int unsigned CurW =
    ((CoordBits > gls_pkg::MapDimBits) ? CoordBits : gls_pkg::MapDimBits) + 2;
  localparam int unsigned TwW = CoordBits + 1;
  localparam int unsigned ErrW = CoordBits + 3;

  // line state
  logic                   active_q, active_d;
  logic [CurW-1:0]        cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [CoordBits-1:0]   origin_x_q, origin_x_d, origin_y_q, origin_y_d;
  logic [CoordBits-1:0]   target_x_q, target_x_d, target_y_q, target_y_d;
  gls_pkg::dir_e          dir_x_q, dir_x_d, dir_y_q, dir_y_d;
  logic [TwW-1:0]         tdx_q, tdx_d, tdy_q, tdy_d;
  logic [ErrW-1:0]        err_q, err_d;
  logic                   x_major_q, x_major_d;
  gls_pkg::stop_rules_t   rules_q, rules_d;

  logic                   fire;
  logic                   is_start;

  // start item terms
  logic [CoordBits:0]     diff_x, diff_y, neg_x, neg_y;
  logic [CoordBits-1:0]   abs_x, abs_y;
  gls_pkg::dir_e          new_dir_x, new_dir_y;
  logic [TwW-1:0]         new_tdx, new_tdy;
  logic                   new_x_major;
  logic [ErrW-1:0]        new_err;
  logic                   same_point;

  // step item terms
  logic                   at_target, at_origin, off_map, stop;
  gls_pkg::dir_e          major_dir;
  logic                   err_pos, minor_go;
  logic [TwW-1:0]         tw_major, tw_minor;
  logic [ErrW-1:0]        err_step;
  logic [CurW-1:0]        dx_ext, dy_ext;

  assign adv_o = out_free_i;
  assign fire = valid_i && out_free_i;
  assign is_start = (ctrl_i.action == gls_pkg::ActStart);

  // endpoint deltas, directions and doubled magnitudes
  assign diff_x = {1'b0, end_x_i} - {1'b0, start_x_i};
  assign diff_y = {1'b0, end_y_i} - {1'b0, start_y_i};
  assign neg_x = ~diff_x + 1'b1;
  assign neg_y = ~diff_y + 1'b1;
  assign abs_x = diff_x[CoordBits] ? neg_x[CoordBits-1:0] : diff_x[CoordBits-1:0];
  assign abs_y = diff_y[CoordBits] ? neg_y[CoordBits-1:0] : diff_y[CoordBits-1:0];
  assign new_dir_x = (diff_x == '0) ? gls_pkg::DirZero :
                     (diff_x[CoordBits] ? gls_pkg::DirNeg : gls_pkg::DirPos);
  assign new_dir_y = (diff_y == '0) ? gls_pkg::DirZero :
                     (diff_y[CoordBits] ? gls_pkg::DirNeg : gls_pkg::DirPos);
  assign new_tdx = {abs_x, 1'b0};
  assign new_tdy = {abs_y, 1'b0};
  assign new_x_major = (abs_x >= abs_y);
  assign new_err = new_x_major ? (ErrW'(new_tdy) - ErrW'(abs_x))
                               : (ErrW'(new_tdx) - ErrW'(abs_y));
  assign same_point = (start_x_i == end_x_i) && (start_y_i == end_y_i);

  // stop test on the point emitted last
  assign at_target = x_major_q ? (cur_x_q == CurW'(target_x_q))
                               : (cur_y_q == CurW'(target_y_q));
  assign at_origin = (cur_x_q == CurW'(origin_x_q)) && (cur_y_q == CurW'(origin_y_q));
  assign off_map = cur_x_q[CurW-1] || cur_y_q[CurW-1] ||
                   (cur_x_q >= CurW'(map_width_i)) || (cur_y_q >= CurW'(map_height_i));
  assign stop = (at_target && rules_q.at_target) || off_map ||
                (ctrl_i.solid && rules_q.solid) ||
                (ctrl_i.opaque && rules_q.opaque) ||
                (ctrl_i.actor && rules_q.actor && !at_origin);

  // error term update, ties step the minor axis on a positive major step
  assign major_dir = x_major_q ? dir_x_q : dir_y_q;
  assign err_pos = !err_q[ErrW-1] && (err_q != '0);
  assign minor_go = err_pos || ((err_q == '0) && (major_dir == gls_pkg::DirPos));
  assign tw_major = x_major_q ? tdx_q : tdy_q;
  assign tw_minor = x_major_q ? tdy_q : tdx_q;
  assign err_step = err_q + ErrW'(tw_minor) - (minor_go ? ErrW'(tw_major) : '0);
  assign dx_ext = {{(CurW-2){dir_x_q[1]}}, dir_x_q};
  assign dy_ext = {{(CurW-2){dir_y_q[1]}}, dir_y_q};

  // next state and result
  always_comb begin
    active_d    = active_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    origin_x_d  = origin_x_q;
    origin_y_d  = origin_y_q;
    target_x_d  = target_x_q;
    target_y_d  = target_y_q;
    dir_x_d     = dir_x_q;
    dir_y_d     = dir_y_q;
    tdx_d       = tdx_q;
    tdy_d       = tdy_q;
    err_d       = err_q;
    x_major_d   = x_major_q;
    rules_d     = rules_q;
    res_we_o    = 1'b0;
    res_flags_o = '{point_valid: 1'b1, last: 1'b0};
    if (fire && is_start) begin
      origin_x_d = start_x_i;
      origin_y_d = start_y_i;
      target_x_d = end_x_i;
      target_y_d = end_y_i;
      rules_d    = ctrl_i.rules;
      cur_x_d    = CurW'(start_x_i);
      cur_y_d    = CurW'(start_y_i);
      res_we_o   = 1'b1;
      if (same_point) begin
        active_d         = 1'b0;
        res_flags_o.last = 1'b1;
      end else begin
        dir_x_d   = new_dir_x;
        dir_y_d   = new_dir_y;
        tdx_d     = new_tdx;
        tdy_d     = new_tdy;
        x_major_d = new_x_major;
        err_d     = new_err;
        active_d  = 1'b1;
      end
    end else if (fire && active_q) begin
      res_we_o = 1'b1;
      if (stop) begin
        active_d    = 1'b0;
        res_flags_o = '{point_valid: 1'b0, last: 1'b1};
      end else begin
        err_d = err_step;
        if (x_major_q || minor_go) begin
          cur_x_d = cur_x_q + dx_ext;
        end
        if (!x_major_q || minor_go) begin
          cur_y_d = cur_y_q + dy_ext;
        end
      end
    end
  end

  assign res_x_o = cur_x_d[gls_pkg::PointBits-1:0];
  assign res_y_o = cur_y_d[gls_pkg::PointBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      cur_x_q    <= '0;
      cur_y_q    <= '0;
      origin_x_q <= '0;
      origin_y_q <= '0;
      target_x_q <= '0;
      target_y_q <= '0;
      dir_x_q    <= gls_pkg::DirZero;
      dir_y_q    <= gls_pkg::DirZero;
      tdx_q      <= '0;
      tdy_q      <= '0;
      err_q      <= '0;
      x_major_q  <= 1'b0;
      rules_q    <= '0;
    end else begin
      active_q   <= active_d;
      cur_x_q    <= cur_x_d;
      cur_y_q    <= cur_y_d;
      origin_x_q <= origin_x_d;
      origin_y_q <= origin_y_d;
      target_x_q <= target_x_d;
      target_y_q <= target_y_d;
      dir_x_q    <= dir_x_d;
      dir_y_q    <= dir_y_d;
      tdx_q      <= tdx_d;
      tdy_q      <= tdy_d;
      err_q      <= err_d;
      x_major_q  <= x_major_d;
      rules_q    <= rules_d;
    end
  end

  // a result is only produced when the output register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_we_o |-> out_free_i)
    else $error("result written while output register is full");

  // a terminal marker always ends the line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_we_o && !res_flags_o.point_valid) |-> res_flags_o.last)
    else $error("terminal marker without last");

  // after the last result no line is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_we_o && res_flags_o.last) |=> !active_q)
    else $error("line still running after last result");

  // every new point of a running line moves along the major axis
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_we_o && !is_start && res_flags_o.point_valid) |=>
      (x_major_q ? (cur_x_q != $past(cur_x_q)) : (cur_y_q != $past(cur_y_q))))
    else $error("step did not advance the major coordinate");

endmodule

FILE: rtl/core/gls_out_stage.sv
module gls_out_stage (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            res_we_i,
  input  logic [gls_pkg::PointBits-1:0]   res_x_i,
  input  logic [gls_pkg::PointBits-1:0]   res_y_i,
  input  gls_pkg::res_flags_t             res_flags_i,
  output logic                            out_free_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [gls_pkg::PointBits-1:0] point_x_o,
  output logic signed [gls_pkg::PointBits-1:0] point_y_o,
  output logic                            point_valid_o,
  output logic                            last_o
);

  logic                          valid_q, valid_d;
  logic [gls_pkg::PointBits-1:0] x_q, y_q;
  gls_pkg::res_flags_t           flags_q;

  // free when empty or when the held result leaves this cycle
  assign out_free_o = !valid_q || !out_stall_i;
  assign valid_d = res_we_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (res_we_i) begin
      x_q     <= res_x_i;
      y_q     <= res_y_i;
      flags_q <= res_flags_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign point_x_o     = x_q;
  assign point_y_o     = y_q;
  assign point_valid_o = flags_q.point_valid;
  assign last_o        = flags_q.last;

endmodule
